// ----- hdl/adjs_pkg.sv -----
// Shared types and constants of the adjacency slot update sampler.
// Request codes, field widths, stream packing sizes and the remainder unit status.
// No dependencies.
package adjs_pkg;

  localparam int REQ_W    = 2;
  localparam int VTX_W    = 11;
  localparam int SLOT_W   = 12;
  localparam int OFFS_W   = 13;
  localparam int NBR_W    = 11;
  localparam int RND_W    = 16;
  localparam int LIVE_W   = 13;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 32;

  localparam logic [REQ_W-1:0] REQ_LOAD_ROW  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_SLOT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_INSERT    = 2'd2;
  localparam logic [REQ_W-1:0] REQ_DELETE    = 2'd3;

  // empty slot marker, -1 in 11 bits
  localparam logic [NBR_W-1:0] EMPTY_NBR = 11'h7FF;

  typedef struct packed {
    logic busy;
    logic done;
  } adjs_mod_stat_t;

endpackage

// ----- hdl/adjs_mod.sv -----
// Iterative remainder unit: one restoring step per cycle over the 16 dividend bits.
// Depends on adjs_pkg for the dividend width and the status struct.
module adjs_mod
  import adjs_pkg::*;
#(
  parameter int DIV_W = 13
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [RND_W-1:0]     dividend,
  input  logic [DIV_W-1:0]     divisor,
  output adjs_mod_stat_t       stat,
  output logic [DIV_W-1:0]     rem
);

  localparam int STEP_W = $clog2(RND_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RND_W - 1);

  logic                busy_r;
  logic                done_r;
  logic [STEP_W-1:0]   step_r;
  logic [RND_W-1:0]    dvd_r;
  logic [DIV_W-1:0]    dsr_r;
  logic [DIV_W-1:0]    rem_r;
  logic [DIV_W-1:0]    rem_nxt;
  logic [DIV_W:0]      shifted;
  logic [DIV_W:0]      trial;

  always_comb begin
    shifted = {rem_r, dvd_r[RND_W-1]};
    trial   = shifted - {1'b0, dsr_r};
    // keep the shifted value on borrow
    rem_nxt = trial[DIV_W] ? shifted[DIV_W-1:0] : trial[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[RND_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = rem_r;

endmodule

// ----- hdl/adjacency_slot_update_sampler_core.sv -----
// Top level of the adjacency slot update sampler: row start and slot memories,
// the update sequencer and the output register. Depends on adjs_pkg and adjs_mod.
//
// channel | dir | handshake            | payload
// --------+-----+----------------------+---------------------------------------------
// in_     | in  | in_tvalid/in_tready  | tuser req_type; tdata vertex..random_value
// out_    | out | out_tvalid/out_tready| tdata picked_neighbor, live_count, slot_changed
//
// A load goes from idle straight to the finish state, whose result enters the output
// register. An update over a row of L slots makes three passes over the single slot
// memory port, reading and then checking each slot (find, count, pick), plus a wait on
// the one-bit-a-step remainder unit, which is skipped when the row has no live slot.
// in_tready is high only while the sequencer is idle; a stalled result waits in the
// output register and the next request is taken meanwhile. Reset clears control
// state only; both memories stay undefined until loaded, so there is no clearing pass.
module adjacency_slot_update_sampler_core
  import adjs_pkg::*;
#(
  parameter int unsigned VERTEX_COUNT = 1024,
  parameter int unsigned SLOT_COUNT   = 4096
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [10:0] vertex, [22:11] slot_index, [35:23] offset_value,
  // [46:36] neighbor, [62:47] random_value, [63] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] req_type
  input  logic [REQ_W-1:0]       in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [10:0] picked_neighbor, [23:11] live_count, [24] slot_changed, [31:25] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int RAW = $clog2(VERTEX_COUNT + 1);
  localparam int SAW = $clog2(SLOT_COUNT);
  localparam int PW  = $clog2(SLOT_COUNT + 1);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_RS_A    = 4'd1;
  localparam logic [3:0] ST_RS_B    = 4'd2;
  localparam logic [3:0] ST_FIND_RD = 4'd3;
  localparam logic [3:0] ST_FIND_CK = 4'd4;
  localparam logic [3:0] ST_CNT_RD  = 4'd5;
  localparam logic [3:0] ST_CNT_CK  = 4'd6;
  localparam logic [3:0] ST_MOD     = 4'd7;
  localparam logic [3:0] ST_PICK_RD = 4'd8;
  localparam logic [3:0] ST_PICK_CK = 4'd9;
  localparam logic [3:0] ST_FIN     = 4'd10;

  // request fields
  logic [REQ_W-1:0]  in_req;
  logic [VTX_W-1:0]  in_vertex;
  logic [SLOT_W-1:0] in_slot;
  logic [OFFS_W-1:0] in_offs;
  logic [NBR_W-1:0]  in_nbr;
  logic [RND_W-1:0]  in_rnd;

  assign in_req    = in_tuser;
  assign in_vertex = in_tdata[10:0];
  assign in_slot   = in_tdata[22:11];
  assign in_offs   = in_tdata[35:23];
  assign in_nbr    = in_tdata[46:36];
  assign in_rnd    = in_tdata[62:47];

  logic [3:0]        state_r;
  logic [VTX_W-1:0]  vtx_r;
  logic [NBR_W-1:0]  want_r;
  logic [NBR_W-1:0]  wr_r;
  logic [RND_W-1:0]  rnd_r;
  logic [PW-1:0]     start_r;
  logic [PW-1:0]     end_r;
  logic [PW-1:0]     ptr_r;
  logic [PW-1:0]     cnt_r;
  logic [PW-1:0]     seen_r;
  logic [PW-1:0]     target_r;
  logic [NBR_W-1:0]  picked_r;
  logic              changed_r;

  logic              out_valid_r;
  logic [NBR_W-1:0]  out_pick_r;
  logic [LIVE_W-1:0] out_cnt_r;
  logic              out_chg_r;

  logic [OFFS_W-1:0] rs_mem [VERTEX_COUNT+1];
  logic [NBR_W-1:0]  sl_mem [SLOT_COUNT];
  logic [OFFS_W-1:0] rs_q_r;
  logic [NBR_W-1:0]  sl_q_r;

  logic              rs_we;
  logic              rs_re;
  logic [RAW-1:0]    rs_addr;
  logic              sl_we;
  logic              sl_re;
  logic [SAW-1:0]    sl_addr;
  logic [NBR_W-1:0]  sl_wdata;

  logic              in_accept;
  logic              is_update;
  logic              vtx_ok;
  logic [31:0]       in_vtx_ext;
  logic [31:0]       vtx1_ext;
  logic [31:0]       in_slot_ext;
  logic [31:0]       rs_ext;
  logic [31:0]       bound_ext;
  logic [31:0]       cnt_ext;
  logic [PW-1:0]     bound;
  logic              in_row;
  logic              out_load;

  logic              mod_start;
  adjs_mod_stat_t    mod_stat;
  logic [PW-1:0]     mod_rem;

  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign is_update = (in_req == REQ_INSERT) || (in_req == REQ_DELETE);

  assign in_vtx_ext  = 32'(in_vertex);
  assign vtx1_ext    = 32'(vtx_r) + 32'd1;
  assign in_slot_ext = 32'(in_slot);
  assign vtx_ok      = in_vtx_ext < VERTEX_COUNT;

  // saturate a row bound at the end of the slot table
  assign rs_ext    = 32'(rs_q_r);
  assign bound_ext = (rs_ext > SLOT_COUNT) ? 32'(SLOT_COUNT) : rs_ext;
  assign bound     = bound_ext[PW-1:0];

  assign in_row   = ptr_r < end_r;
  assign cnt_ext  = 32'(cnt_r);
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  assign mod_start = (state_r == ST_CNT_RD) && !in_row && (cnt_r != '0);

  always_comb begin
    rs_we    = 1'b0;
    rs_re    = 1'b0;
    rs_addr  = in_vtx_ext[RAW-1:0];
    sl_we    = 1'b0;
    sl_re    = 1'b0;
    sl_addr  = ptr_r[SAW-1:0];
    sl_wdata = wr_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_req == REQ_LOAD_ROW && in_vtx_ext <= VERTEX_COUNT) begin
            rs_we = 1'b1;
          end
          if (in_req == REQ_LOAD_SLOT && in_slot_ext < SLOT_COUNT) begin
            sl_we    = 1'b1;
            sl_addr  = in_slot_ext[SAW-1:0];
            sl_wdata = in_nbr;
          end
          if (is_update && vtx_ok) begin
            rs_re = 1'b1;
          end
        end
      end
      ST_RS_A: begin
        rs_re   = 1'b1;
        rs_addr = vtx1_ext[RAW-1:0];
      end
      ST_FIND_RD, ST_CNT_RD, ST_PICK_RD: begin
        sl_re = in_row;
      end
      ST_FIND_CK: begin
        sl_we = (sl_q_r == want_r);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rs_we) begin
      rs_mem[rs_addr] <= in_offs;
    end
    if (rs_re) begin
      rs_q_r <= rs_mem[rs_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (sl_we) begin
      sl_mem[sl_addr] <= sl_wdata;
    end
    if (sl_re) begin
      sl_q_r <= sl_mem[sl_addr];
    end
  end

  adjs_mod #(
    .DIV_W (PW)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (rnd_r),
    .divisor  (cnt_r),
    .stat     (mod_stat),
    .rem      (mod_rem)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            state_r <= (is_update && vtx_ok) ? ST_RS_A : ST_FIN;
          end
        end
        ST_RS_A:    state_r <= ST_RS_B;
        ST_RS_B:    state_r <= ST_FIND_RD;
        ST_FIND_RD: state_r <= in_row ? ST_FIND_CK : ST_CNT_RD;
        ST_FIND_CK: state_r <= (sl_q_r == want_r) ? ST_CNT_RD : ST_FIND_RD;
        ST_CNT_RD: begin
          if (in_row) begin
            state_r <= ST_CNT_CK;
          end else begin
            state_r <= (cnt_r != '0) ? ST_MOD : ST_FIN;
          end
        end
        ST_CNT_CK: state_r <= ST_CNT_RD;
        ST_MOD: begin
          if (mod_stat.done) begin
            state_r <= ST_PICK_RD;
          end
        end
        ST_PICK_RD: state_r <= in_row ? ST_PICK_CK : ST_FIN;
        ST_PICK_CK: begin
          if (sl_q_r != EMPTY_NBR && seen_r == target_r) begin
            state_r <= ST_FIN;
          end else begin
            state_r <= ST_PICK_RD;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        vtx_r     <= in_vertex;
        rnd_r     <= in_rnd;
        want_r    <= (in_req == REQ_INSERT) ? EMPTY_NBR : in_nbr;
        wr_r      <= (in_req == REQ_INSERT) ? in_nbr : EMPTY_NBR;
        picked_r  <= EMPTY_NBR;
        cnt_r     <= '0;
        changed_r <= 1'b0;
      end
      ST_RS_A: begin
        start_r <= bound;
      end
      ST_RS_B: begin
        end_r <= bound;
        ptr_r <= start_r;
      end
      ST_FIND_RD: begin
        if (!in_row) begin
          ptr_r <= start_r;
        end
      end
      ST_FIND_CK: begin
        if (sl_q_r == want_r) begin
          changed_r <= 1'b1;
          ptr_r     <= start_r;
        end else begin
          ptr_r <= ptr_r + 1'b1;
        end
      end
      ST_CNT_RD: begin
        if (!in_row) begin
          ptr_r <= start_r;
        end
      end
      ST_CNT_CK: begin
        if (sl_q_r != EMPTY_NBR) begin
          cnt_r <= cnt_r + 1'b1;
        end
        ptr_r <= ptr_r + 1'b1;
      end
      ST_MOD: begin
        target_r <= mod_rem;
        seen_r   <= '0;
      end
      ST_PICK_CK: begin
        if (sl_q_r != EMPTY_NBR) begin
          if (seen_r == target_r) begin
            picked_r <= sl_q_r;
          end else begin
            seen_r <= seen_r + 1'b1;
          end
        end
        ptr_r <= ptr_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pick_r <= picked_r;
      out_cnt_r  <= cnt_ext[LIVE_W-1:0];
      out_chg_r  <= changed_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_chg_r, out_cnt_r, out_pick_r};

`ifndef ASSERT_OFF
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r != ST_IDLE))
    else $error("request accepted without leaving idle");

  a_check_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIND_CK || state_r == ST_CNT_CK || state_r == ST_PICK_CK)
      |-> (ptr_r < end_r))
    else $error("slot check outside the row");

  a_mod_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOD) |-> (mod_stat.busy || mod_stat.done))
    else $error("waiting on an idle remainder unit");

  a_target_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PICK_RD || state_r == ST_PICK_CK) |-> (target_r < cnt_r))
    else $error("pick target not below live count");
`endif

endmodule
